FILE: rtl/tpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types, constants and helpers of the trapezoid profile generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam logic [2:0] REG_START_POS  = 3'd0;
  localparam logic [2:0] REG_TARGET_POS = 3'd1;
  localparam logic [2:0] REG_PROF_VEL   = 3'd2;
  localparam logic [2:0] REG_PROF_ACCEL = 3'd3;
  localparam logic [2:0] REG_TOTAL_TIME = 3'd4;

  localparam logic [50:0] DCAP    = 51'h4_0000_0000_0000;
  localparam logic [39:0] VEL_MAX = 40'hFF_FFFF_FFFF;
  localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ISSUE,
    S_WAIT,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_VEL_ACC,
    OP_SQ_T,
    OP_SQ_TA,
    OP_SQ_TD,
    OP_HALF_POS,
    OP_HALF_DDEC,
    OP_CRUISE,
    OP_DV,
    OP_DCONST,
    OP_DVEC
  } op_t;

  typedef enum logic [1:0] {
    PH_ACCEL,
    PH_CRUISE,
    PH_DECEL
  } phase_t;

  typedef enum logic [1:0] {
    K_START,
    K_HOLD,
    K_FINISH,
    K_COMPUTE
  } kind_t;

  typedef struct packed {
    logic accept;
    logic go;
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    kind_t  kind;
    phase_t phase;
    logic   div_done;
    logic   mul_done;
    logic   out_full;
  } stat_t;

  function automatic op_t prog_op(input phase_t ph, input logic [2:0] step);
    op_t r;
    r = OP_SQ_TA;
    unique case (ph)
      PH_ACCEL: begin
        case (step)
          3'd0:    r = OP_VEL_ACC;
          3'd1:    r = OP_SQ_T;
          default: r = OP_HALF_POS;
        endcase
      end
      PH_CRUISE: begin
        case (step)
          3'd0:    r = OP_SQ_TA;
          3'd1:    r = OP_HALF_POS;
          default: r = OP_CRUISE;
        endcase
      end
      default: begin
        case (step)
          3'd0:    r = OP_DV;
          3'd1:    r = OP_SQ_TA;
          3'd2:    r = OP_HALF_POS;
          3'd3:    r = OP_DCONST;
          3'd4:    r = OP_DVEC;
          3'd5:    r = OP_SQ_TD;
          default: r = OP_HALF_DDEC;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] prog_last(input phase_t ph);
    logic [2:0] r;
    r = 3'd6;
    unique case (ph)
      PH_ACCEL:  r = 3'd2;
      PH_CRUISE: r = 3'd2;
      default:   r = 3'd6;
    endcase
    return r;
  endfunction

  function automatic logic [50:0] cap50(input logic [111:0] x);
    logic [50:0] r;
    r = x[50:0];
    if ((|x[111:51]) || (x[50:0] > DCAP)) r = DCAP;
    return r;
  endfunction

  function automatic logic signed [47:0] sat53(input logic signed [52:0] x);
    logic signed [47:0] r;
    r = x[47:0];
    if (!((&x[52:47]) || !(|x[52:47]))) r = x[52] ? POS_MIN : POS_MAX;
    return r;
  endfunction

endpackage

FILE: rtl/tpg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_mul
// 64x64 multiplier built from four 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module tpg_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [63:0]  x,
  input  logic [63:0]  y,
  output logic         busy,
  output logic         done,
  output logic [127:0] prod
);

  logic [1:0]   cnt;
  logic [63:0]  x_r;
  logic [63:0]  y_r;
  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [63:0]  pp;
  logic [127:0] term;

  assign xs = cnt[1] ? x_r[63:32] : x_r[31:0];
  assign ys = cnt[0] ? y_r[63:32] : y_r[31:0];
  assign pp = xs * ys;

  always_comb begin
    case (cnt)
      2'd0:    term = {64'd0, pp};
      2'd3:    term = {pp, 64'd0};
      default: term = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r  <= x;
      y_r  <= y;
      prod <= '0;
    end else if (busy) begin
      prod <= prod + term;
    end
  end

endmodule

FILE: rtl/tpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module tpg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [55:0] num,
  input  logic [39:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic        busy;
  logic [5:0]  cnt;
  logic [39:0] rem;
  logic [55:0] q;
  logic [40:0] trial;
  logic        qbit;

  assign trial = {rem, q[55]};
  assign qbit  = trial >= {1'b0, den};
  assign quo   = (|q[55:32]) ? 32'hFFFF_FFFF : q[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd55) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      q   <= num;
    end else if (busy) begin
      rem <= qbit ? 40'(trial - {1'b0, den}) : trial[39:0];
      q   <= {q[54:0], qbit};
    end
  end

endmodule

FILE: rtl/tpg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_ctrl
// Sequencer: accepts items, steps the product program, loads results.
// ----------------------------------------------------------------------------
module tpg_ctrl
  import tpg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t st,
  output logic  in_stall,
  output cmd_t  cmd
);

  state_t     state;
  state_t     state_next;
  logic [2:0] step;
  logic       last;

  assign last = step == prog_last(st.phase);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (st.kind)
            K_START:   state_next = S_DIV;
            K_COMPUTE: state_next = S_ISSUE;
            default:   state_next = S_OUT;
          endcase
        end
      end
      S_DIV:   if (st.div_done) state_next = S_OUT;
      S_ISSUE: state_next = S_WAIT;
      S_WAIT:  if (st.mul_done) state_next = last ? S_OUT : S_ISSUE;
      S_OUT:   if (!st.out_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = state != S_IDLE;
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.go     = state == S_ISSUE;
    cmd.op     = prog_op(st.phase, step);
    cmd.load   = (state == S_OUT) && !st.out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        step <= '0;
      end else if ((state == S_WAIT) && st.mul_done) begin
        step <= step + 3'd1;
      end
    end
  end

endmodule

FILE: rtl/tpg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_dp
// Datapath: registers, move state, shared multiplier, divider, output item.
// ----------------------------------------------------------------------------
module tpg_dp
  import tpg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  input  logic                action,
  input  logic [31:0]         dt,
  input  cmd_t                cmd,
  output stat_t               st,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [47:0]  pos_cmd,
  output logic [39:0]         vel_cmd,
  output logic signed [47:0]  remaining,
  output logic                move_done
);

  logic signed [47:0] start_reg;
  logic signed [47:0] target_reg;
  logic [39:0]        prof_v;
  logic [39:0]        prof_a;
  logic [31:0]        tot;

  logic [31:0]        elapsed;
  logic [31:0]        ramp;
  logic               running;
  logic               finished;
  logic signed [47:0] pos;
  logic [39:0]        vel;
  logic [63:0]        sq;
  logic [50:0]        mreg;
  op_t                op_r;

  logic [32:0]        sum;
  kind_t              kind;
  logic [32:0]        tpa;
  logic [31:0]        td;
  logic [33:0]        diff;
  logic [33:0]        diff_mag;
  logic [31:0]        tsub;
  logic [63:0]        mx;
  logic [63:0]        my;
  logic               mul_busy;
  logic               mul_done;
  logic [127:0]       prod;
  logic               div_done;
  logic [31:0]        quo;
  logic [50:0]        c16;
  logic [50:0]        h;
  logic [39:0]        c16v;
  logic signed [52:0] delta;
  logic signed [47:0] pos_new;
  logic signed [48:0] rdiff;
  logic signed [47:0] rem_sat;

  assign sum = {1'b0, elapsed} + {1'b0, dt};

  always_comb begin
    if (action) kind = K_START;
    else if (!running || finished) kind = K_HOLD;
    else if (sum >= {1'b0, tot}) kind = K_FINISH;
    else kind = K_COMPUTE;
  end

  assign tpa      = {1'b0, elapsed} + {1'b0, ramp};
  assign td       = 32'(tpa - {1'b0, tot});
  assign diff     = {2'b00, tot} - {1'b0, ramp, 1'b0};
  assign diff_mag = diff[33] ? 34'(-diff) : diff;
  assign tsub     = elapsed - ramp;

  always_comb begin
    st.kind = kind;
    if (elapsed <= ramp) st.phase = PH_ACCEL;
    else if (tpa >= {1'b0, tot}) st.phase = PH_DECEL;
    else st.phase = PH_CRUISE;
    st.div_done = div_done;
    st.mul_done = mul_done;
    st.out_full = out_valid && out_stall;
  end

  always_comb begin
    mx = {24'd0, prof_a};
    my = sq;
    case (cmd.op)
      OP_VEL_ACC: my = {32'd0, elapsed};
      OP_SQ_T: begin
        mx = {32'd0, elapsed};
        my = {32'd0, elapsed};
      end
      OP_SQ_TA: begin
        mx = {32'd0, ramp};
        my = {32'd0, ramp};
      end
      OP_SQ_TD: begin
        mx = {32'd0, td};
        my = {32'd0, td};
      end
      OP_CRUISE: begin
        mx = {24'd0, prof_v};
        my = {32'd0, tsub};
      end
      OP_DV:     my = {32'd0, td};
      OP_DCONST: begin
        mx = {24'd0, prof_v};
        my = {30'd0, diff_mag};
      end
      OP_DVEC: begin
        mx = {24'd0, prof_v};
        my = {32'd0, td};
      end
      default: my = sq;
    endcase
  end

  tpg_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.go),
    .x    (mx),
    .y    (my),
    .busy (mul_busy),
    .done (mul_done),
    .prod (prod)
  );

  tpg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.accept && (kind == K_START)),
    .num  ({prof_v, 16'd0}),
    .den  (prof_a),
    .done (div_done),
    .quo  (quo)
  );

  assign c16  = cap50(prod[127:16]);
  assign h    = cap50({17'd0, prod[127:33]});
  assign c16v = (|prod[127:56]) ? VEL_MAX : prod[55:16];

  always_comb begin
    case (op_r)
      OP_HALF_DDEC: delta = $signed({2'b00, mreg}) - $signed({2'b00, h});
      OP_CRUISE:    delta = $signed({2'b00, c16});
      OP_DCONST:    delta = diff[33] ? -$signed({2'b00, c16}) : $signed({2'b00, c16});
      default:      delta = $signed({2'b00, h});
    endcase
  end

  assign pos_new = sat53({{5{pos[47]}}, pos} + delta);
  assign rdiff   = {target_reg[47], target_reg} - {pos[47], pos};
  assign rem_sat = (rdiff[48] != rdiff[47]) ? (rdiff[48] ? POS_MIN : POS_MAX)
                                            : rdiff[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg  <= '0;
      target_reg <= '0;
      prof_v     <= '0;
      prof_a     <= '0;
      tot        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_POS:  start_reg  <= cfg_data;
        REG_TARGET_POS: target_reg <= cfg_data;
        REG_PROF_VEL:   prof_v     <= cfg_data[39:0];
        REG_PROF_ACCEL: prof_a     <= cfg_data[39:0];
        REG_TOTAL_TIME: tot        <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed   <= '0;
      ramp      <= '0;
      running   <= 1'b0;
      finished  <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        unique case (kind)
          K_START: begin
            elapsed  <= '0;
            running  <= 1'b1;
            finished <= 1'b0;
            pos      <= start_reg;
          end
          K_FINISH: begin
            elapsed  <= tot;
            running  <= 1'b0;
            finished <= 1'b1;
            pos      <= target_reg;
          end
          K_COMPUTE: begin
            elapsed <= sum[31:0];
            pos     <= start_reg;
          end
          default: ;
        endcase
      end
      if (div_done) ramp <= (prof_a == '0) ? '0 : quo;
      if (mul_done) begin
        case (op_r)
          OP_HALF_POS, OP_HALF_DDEC, OP_CRUISE, OP_DCONST: pos <= pos_new;
          default: ;
        endcase
      end
      if (cmd.load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) vel <= (kind == K_COMPUTE) ? prof_v : '0;
    if (cmd.go) op_r <= cmd.op;
    if (mul_done) begin
      case (op_r)
        OP_VEL_ACC: vel <= c16v;
        OP_SQ_T, OP_SQ_TA, OP_SQ_TD: sq <= prod[63:0];
        OP_DV: vel <= ({11'd0, prof_v} <= c16) ? '0 : 40'(prof_v - c16[39:0]);
        OP_DVEC: mreg <= c16;
        default: ;
      endcase
    end
    if (cmd.load) begin
      pos_cmd   <= pos;
      vel_cmd   <= vel;
      remaining <= rem_sat;
      move_done <= finished;
    end
  end

`ifndef SYNTHESIS
  a_mul_free: assert property (@(posedge clk) disable iff (rst) cmd.go |-> !mul_busy)
    else $error("product issued while multiplier busy");
  a_flags: assert property (@(posedge clk) disable iff (rst) !(running && finished))
    else $error("move both running and finished");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && (kind == K_START)) |=> ((elapsed == '0) && running && !finished))
    else $error("start did not arm the move");
`endif

endmodule

FILE: rtl/trapezoid_profile_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_profile_generator_top
// Trapezoidal motion profile generator, one result item per input item.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    action, dt
//   out      out_valid / out_stall  pos_cmd, vel_cmd, remaining, move_done
//   cfg      cfg_we                 cfg_index, cfg_data
//
// Start item: waits on the 56-step ramp time divider.
// Tick item: n products on the shared multiplier, n = 3 products (ramp or cruise)
// or 7 (decel); idle or completing ticks issue no products.
// Reset clears the move state and registers; one item is worked at a time.
// A stalled result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module trapezoid_profile_generator_top
  import tpg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [31:0]         dt,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  pos_cmd,
  output logic [39:0]         vel_cmd,
  output logic signed [47:0]  remaining,
  output logic                move_done
);

  cmd_t  cmd;
  stat_t st;

  tpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tpg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (action),
    .dt        (dt),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .pos_cmd   (pos_cmd),
    .vel_cmd   (vel_cmd),
    .remaining (remaining),
    .move_done (move_done)
  );

endmodule

FILE: test/trapezoid_profile_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_profile_generator_top_tb
// Drives start and tick items through several profile settings, with random
// idling on both sides and a long output hold-off, and checks every result
// item against a cycle-free model of the trapezoidal profile.
// ----------------------------------------------------------------------------
module trapezoid_profile_generator_top_tb;
  import tpg_pkg::*;

  typedef struct packed {
    logic signed [47:0] pos;
    logic [39:0]        vel;
    logic signed [47:0] rem;
    logic               done;
  } profile_point_t;

  class profile_scoreboard;
    logic [47:0] start_reg, target_reg;
    logic [39:0] prof_vel, prof_acc;
    logic [31:0] total_t;
    logic [31:0] elapsed_t, ramp_t;
    logic signed [47:0] pos_now;
    logic running, finished;
    profile_point_t pending[$];
    int errors;

    function new();
      start_reg = '0; target_reg = '0; prof_vel = '0; prof_acc = '0; total_t = '0;
      elapsed_t = '0; ramp_t = '0; pos_now = '0; running = 1'b0; finished = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        REG_START_POS:  start_reg = val;
        REG_TARGET_POS: target_reg = val;
        REG_PROF_VEL:   prof_vel = val[39:0];
        REG_PROF_ACCEL: prof_acc = val[39:0];
        REG_TOTAL_TIME: total_t = val[31:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] scaled_product(logic [63:0] x, logic [63:0] y, int sh,
                                         logic [63:0] lim);
      logic [127:0] p;
      p = x * y;
      p = p >> sh;
      if (p > {64'd0, lim}) return lim;
      return p[63:0];
    endfunction

    function longint clip48(longint x);
      if (x > longint'(POS_MAX)) return longint'(POS_MAX);
      if (x < longint'(POS_MIN)) return longint'(POS_MIN);
      return x;
    endfunction

    function longint half_term(logic [63:0] t);
      logic [63:0] sq;
      sq = t * t;
      return longint'(scaled_product({24'd0, prof_acc}, sq, 33, 64'(DCAP)));
    endfunction

    function void emit_point(longint p, logic [39:0] v);
      profile_point_t e;
      e.pos = p[47:0];
      e.vel = v;
      e.rem = 48'(clip48(longint'($signed(target_reg)) - p));
      e.done = finished;
      pending.push_back(e);
    endfunction

    function void note_item(logic act, logic [31:0] step);
      logic [63:0] a, v, tot, sum, t, ta, td, dv, q;
      longint tds, p, diff, dconst;
      logic [39:0] vel;
      a = 64'(prof_acc); v = 64'(prof_vel); tot = 64'(total_t);
      if (act) begin
        q = '0;
        if (a != 0) begin
          q = (v << 16) / a;
          if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        end
        ramp_t = q[31:0];
        pos_now = start_reg;
        elapsed_t = '0; running = 1'b1; finished = 1'b0;
        emit_point(pos_now, '0);
        return;
      end
      if (!running || finished) begin
        emit_point(pos_now, '0);
        return;
      end
      sum = 64'(elapsed_t) + 64'(step);
      if (sum >= tot) begin
        elapsed_t = tot[31:0];
        pos_now = target_reg;
        finished = 1'b1; running = 1'b0;
        emit_point(pos_now, '0);
        return;
      end
      elapsed_t = sum[31:0];
      t = 64'(elapsed_t); ta = 64'(ramp_t);
      tds = longint'(tot) - longint'(ta);
      p = longint'($signed(start_reg));
      if (t <= ta) begin
        vel = 40'(scaled_product(a, t, 16, 64'(VEL_MAX)));
        p = clip48(p + half_term(t));
      end else if (longint'(t) >= tds) begin
        td = 64'(longint'(t) - tds);
        dv = scaled_product(a, td, 16, 64'(DCAP));
        vel = (dv >= v) ? 40'd0 : 40'(v - dv);
        diff = longint'(tot) - 2 * longint'(ta);
        if (diff >= 0) dconst = longint'(scaled_product(v, 64'(diff), 16, 64'(DCAP)));
        else dconst = -longint'(scaled_product(v, 64'(-diff), 16, 64'(DCAP)));
        p = clip48(p + half_term(ta));
        p = clip48(p + dconst);
        p = clip48(p + longint'(scaled_product(v, td, 16, 64'(DCAP))) - half_term(td));
      end else begin
        vel = v[39:0];
        p = clip48(p + half_term(ta));
        p = clip48(p + longint'(scaled_product(v, t - ta, 16, 64'(DCAP))));
      end
      pos_now = p[47:0];
      emit_point(p, vel);
    endfunction

    function void check_result(profile_point_t got);
      profile_point_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item pos=%0d", got.pos);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp pos=%0d vel=%0d rem=%0d done=%0b",
                   e.pos, e.vel, e.rem, e.done);
          $display("          got pos=%0d vel=%0d rem=%0d done=%0b",
                   got.pos, got.vel, got.rem, got.done);
        end
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic action = 0;
  logic [31:0] dt = '0;
  logic out_valid, out_stall = 0;
  logic signed [47:0] pos_cmd, remaining;
  logic [39:0] vel_cmd;
  logic move_done;

  profile_scoreboard sb = new();
  int idle_pct_in = 10, idle_pct_out = 10;
  int hold_off = 0;
  int quiet_cycles = 0;
  localparam int WATCHDOG = 20000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  trapezoid_profile_generator_top i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall, .action, .dt,
    .out_valid, .out_stall, .pos_cmd, .vel_cmd, .remaining, .move_done
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(action, dt);
      if (out_valid && !out_stall) sb.check_result({pos_cmd, vel_cmd, remaining, move_done});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random stall, or a counted hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct_out);
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_item(logic act, logic [31:0] step);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; action <= act; dt <= step;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic end_items();
    in_valid <= 0;
  endtask

  task automatic set_profile(logic [47:0] sp, logic [47:0] tp, logic [39:0] v,
                             logic [39:0] a, logic [31:0] tt);
    write_cfg(REG_START_POS, sp);
    write_cfg(REG_TARGET_POS, tp);
    write_cfg(REG_PROF_VEL, {8'd0, v});
    write_cfg(REG_PROF_ACCEL, {8'd0, a});
    write_cfg(REG_TOTAL_TIME, {16'd0, tt});
  endtask

  task automatic run_move(int n_ticks, logic [31:0] max_dt);
    send_item(1'b1, $urandom);
    for (int k = 0; k < n_ticks; k++)
      send_item(($urandom_range(99) < 3), $urandom_range(max_dt));
  endtask

  logic [31:0] tt;
  int sent;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // idle ticks before any move
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b0, 32'd0);
    end_items(); drain();
    // typical profile
    set_profile(48'd1000 << 16, 48'd5000 << 16, 40'd100 << 16, 40'd50 << 16, 32'd10 << 16);
    send_item(1'b1, 32'd0);
    send_item(1'b0, 32'd0);
    send_item(1'b0, 32'h0001_0000);
    send_item(1'b1, 32'd0);
    for (int k = 0; k < 8; k++) send_item(1'b0, 32'h0001_8000);
    send_item(1'b0, 32'd5);
    end_items(); drain();
    // extremes: zero accel, zero total time, full-scale values
    set_profile(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'd0, 32'd0);
    send_item(1'b1, 32'd0);
    send_item(1'b0, 32'd0);
    send_item(1'b0, 32'd1);
    end_items(); drain();
    write_cfg(REG_TOTAL_TIME, 48'hFFFF_FFFF);
    send_item(1'b1, 32'd0);
    send_item(1'b0, 32'h0000_0001);
    send_item(1'b0, 32'hFFFF_FFFF);
    end_items(); drain();
    set_profile(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 40'hFF_FFFF_FFFF,
                40'd1, 32'hFFFF_FFFF);
    send_item(1'b1, 32'd0);
    send_item(1'b0, 32'h8000_0000);
    send_item(1'b0, 32'h7FFF_FFFF);
    end_items(); drain();
    // random phases; long hold-off during the second one
    sent = 0;
    for (int ph = 0; sent < 1100; ph++) begin
      tt = (ph % 4 == 0) ? $urandom : $urandom_range(32'h0010_0000);
      set_profile(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                  (ph % 5 == 0) ? 40'({$urandom, $urandom})
                                : 40'($urandom_range(32'h0100_0000)),
                  (ph % 7 == 0) ? 40'd0 :
                  (ph % 5 == 1) ? 40'({$urandom, $urandom})
                                : 40'($urandom_range(32'h0200_0000)),
                  tt);
      idle_pct_in = (ph % 3 == 2) ? 0 : 10;
      idle_pct_out = (ph % 3 == 2) ? 0 : 10;
      if (ph == 1) hold_off <= 600;
      for (int m = 0; m < 3; m++) begin
        run_move(12, (tt >> 3) + 1);
        sent += 13;
      end
      if ($urandom_range(99) < 20) begin
        send_item(1'b0, $urandom);
        sent++;
      end
      end_items();
      drain();
    end
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
